// ===== sv/sorted_set_neighbor_search_macros.svh =====
// ----------------------------------------------------------------------------
// sorted_set_neighbor_search_macros
// Assertion macros for the sorted set neighbor search block.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_NEIGHBOR_SEARCH_MACROS_SVH
`define SORTED_SET_NEIGHBOR_SEARCH_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define SSNS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define SSNS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/ssns_pkg.sv =====
// ----------------------------------------------------------------------------
// ssns_pkg
// Types, constants and command structures shared by the neighbor search block.
// ----------------------------------------------------------------------------
package ssns_pkg;

  localparam int unsigned ValW        = 31;
  localparam int unsigned StatW       = 2;
  localparam int unsigned DefCapacity = 1024;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_QUERY     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_LO_RD,
    S_LO_CAP,
    S_UP_RD,
    S_UP_CAP,
    S_OUT
  } state_e;

  typedef enum logic [2:0] {
    RA_MID,
    RA_SHIFT,
    RA_LOWER,
    RA_UPPER,
    RA_NONE
  } raddr_sel_e;

  // Controller to datapath.
  typedef struct packed {
    logic       load_item;   // capture the accepted beat and reset search
    logic       rd_en;
    raddr_sel_e rsel;
    logic       srch_step;   // narrow the search window with read data
    logic       shift_wr;    // write shifted entry one place up
    logic       ins_wr;      // write key at the insertion point
    logic       shift_dec;   // move the shift pointer down
    logic       cap_lower;
    logic       cap_upper;
    logic       set_result;  // build the result from captured fields
    logic       out_valid;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_query;
    logic srch_done;
    logic found;
    logic full;
    logic shift_done;
    logic out_taken;
  } dp_stat_t;

endpackage

// ===== sv/ssns_if.sv =====
// ----------------------------------------------------------------------------
// ssns_in_if / ssns_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface ssns_in_if;
  import ssns_pkg::*;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [ValW-1:0]   value;
  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface ssns_out_if;
  import ssns_pkg::*;
  logic              valid;
  logic              ready;
  logic [StatW-1:0]  status;
  logic              has_lower;
  logic [ValW-1:0]   lower_value;
  logic              has_upper;
  logic [ValW-1:0]   upper_value;
  modport source (output valid, status, has_lower, lower_value, has_upper,
                  upper_value, input ready);
  modport sink   (input valid, status, has_lower, lower_value, has_upper,
                  upper_value, output ready);
endinterface

// ===== sv/ssns_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssns_ctrl
// Sequencer for search, shift-insert and neighbor read-out.
// ----------------------------------------------------------------------------
module ssns_ctrl
  import ssns_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o,
  output state_e    state_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o = state_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:     if (in_valid_i) state_d = S_SRCH_RD;
      S_SRCH_RD:  state_d = stat_i.srch_done ? S_DECIDE : S_SRCH_CMP;
      S_SRCH_CMP: state_d = S_SRCH_RD;
      S_DECIDE: begin
        if (stat_i.is_query) state_d = S_LO_RD;
        else if (stat_i.found || stat_i.full) state_d = S_OUT;
        else state_d = stat_i.shift_done ? S_INS_WR : S_SHIFT_RD;
      end
      S_SHIFT_RD: state_d = S_SHIFT_WR;
      S_SHIFT_WR: state_d = stat_i.shift_done ? S_INS_WR : S_SHIFT_RD;
      S_INS_WR:   state_d = S_OUT;
      S_LO_RD:    state_d = S_LO_CAP;
      S_LO_CAP:   state_d = S_UP_RD;
      S_UP_RD:    state_d = S_UP_CAP;
      S_UP_CAP:   state_d = S_OUT;
      S_OUT:      if (stat_i.out_taken) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.rsel = RA_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      S_SRCH_RD: begin
        cmd_o.rd_en = !stat_i.srch_done;
        cmd_o.rsel  = RA_MID;
      end
      S_SRCH_CMP: cmd_o.srch_step = 1'b1;
      S_DECIDE:   cmd_o.set_result = 1'b1;
      S_SHIFT_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rsel  = RA_SHIFT;
      end
      S_SHIFT_WR: begin
        cmd_o.shift_wr  = 1'b1;
        cmd_o.shift_dec = 1'b1;
      end
      S_INS_WR:   cmd_o.ins_wr = 1'b1;
      S_LO_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rsel  = RA_LOWER;
      end
      S_LO_CAP:   cmd_o.cap_lower = 1'b1;
      S_UP_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rsel  = RA_UPPER;
      end
      S_UP_CAP:   cmd_o.cap_upper = 1'b1;
      S_OUT:      cmd_o.out_valid = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== sv/ssns_dp.sv =====
// ----------------------------------------------------------------------------
// ssns_dp
// Value memory, binary search window, shift pointer and result registers.
// ----------------------------------------------------------------------------
module ssns_dp
  import ssns_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_cmd_t         cmd_i,
  output dp_stat_t          stat_o,
  input  logic              in_kind_i,
  input  logic [ValW-1:0]   in_value_i,
  input  logic              out_ready_i,
  output logic [StatW-1:0]  status_o,
  output logic              has_lower_o,
  output logic [ValW-1:0]   lower_value_o,
  output logic              has_upper_o,
  output logic [ValW-1:0]   upper_value_o,
  output logic [$clog2(CAPACITY+1)-1:0] count_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic [ValW-1:0] mem_q [CAPACITY];
  logic [ValW-1:0] rdata_q;

  logic            kind_q;
  logic [ValW-1:0] key_q;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [CW-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic [CW-1:0]   sp_q, sp_d;        // next destination of the shift
  logic            found_q, found_d;
  logic [StatW-1:0] status_q, status_d;
  logic            hl_q, hl_d, hu_q, hu_d;
  logic [ValW-1:0] lv_q, lv_d, uv_q, uv_d;

  logic [CW-1:0]   mid;
  logic [CW-1:0]   up_idx;
  logic [CW-1:0]   raddr_full;
  logic [CW-1:0]   waddr_full;
  logic            we;
  logic [ValW-1:0] wdata;

  assign mid    = lo_q + ((hi_q - lo_q) >> 1);
  assign up_idx = found_q ? lo_q + CW'(1) : lo_q;

  always_comb begin
    unique case (cmd_i.rsel)
      RA_MID:   raddr_full = mid;
      RA_SHIFT: raddr_full = sp_q - CW'(1);
      RA_LOWER: raddr_full = lo_q - CW'(1);
      RA_UPPER: raddr_full = up_idx;
      default:  raddr_full = '0;
    endcase
  end

  assign we         = cmd_i.shift_wr || cmd_i.ins_wr;
  assign waddr_full = cmd_i.ins_wr ? lo_q : sp_q;
  assign wdata      = cmd_i.ins_wr ? key_q : rdata_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr_full[AW-1:0]] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr_full[AW-1:0]];
    end
  end

  always_comb begin
    cnt_d    = cnt_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    sp_d     = sp_q;
    found_d  = found_q;
    status_d = status_q;
    hl_d     = hl_q;
    hu_d     = hu_q;
    lv_d     = lv_q;
    uv_d     = uv_q;
    if (cmd_i.load_item) begin
      lo_d    = '0;
      hi_d    = cnt_q;
      sp_d    = cnt_q;
      found_d = 1'b0;
    end
    if (cmd_i.srch_step) begin
      if (rdata_q < key_q) begin
        lo_d = mid + CW'(1);
      end else begin
        hi_d = mid;
      end
      if (rdata_q == key_q) found_d = 1'b1;
    end
    if (cmd_i.set_result) begin
      hl_d = 1'b0;
      hu_d = 1'b0;
      lv_d = '0;
      uv_d = '0;
      if (kind_q) status_d = ST_QUERY;
      else if (found_q) status_d = ST_DUPLICATE;
      else if (cnt_q >= CW'(CAPACITY)) status_d = ST_FULL;
      else status_d = ST_INSERTED;
    end
    if (cmd_i.shift_dec) sp_d = sp_q - CW'(1);
    if (cmd_i.ins_wr) cnt_d = cnt_q + CW'(1);
    if (cmd_i.cap_lower && (lo_q != '0)) begin
      hl_d = 1'b1;
      lv_d = rdata_q;
    end
    if (cmd_i.cap_upper && (up_idx < cnt_q)) begin
      hu_d = 1'b1;
      uv_d = rdata_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      kind_q <= in_kind_i;
      key_q  <= in_value_i;
    end
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    sp_q     <= sp_d;
    found_q  <= found_d;
    status_q <= status_d;
    hl_q     <= hl_d;
    hu_q     <= hu_d;
    lv_q     <= lv_d;
    uv_q     <= uv_d;
  end

  assign stat_o.is_query   = kind_q;
  assign stat_o.srch_done  = (lo_q >= hi_q);
  assign stat_o.found      = found_q;
  assign stat_o.full       = (cnt_q >= CW'(CAPACITY));
  assign stat_o.shift_done = (sp_q == lo_q) ||
                             (cmd_i.shift_dec && ((sp_q - CW'(1)) == lo_q));
  assign stat_o.out_taken  = cmd_i.out_valid && out_ready_i;

  assign status_o      = status_q;
  assign has_lower_o   = hl_q;
  assign lower_value_o = lv_q;
  assign has_upper_o   = hu_q;
  assign upper_value_o = uv_q;
  assign count_o       = cnt_q;

endmodule

// ===== sv/sorted_set_neighbor_search.sv =====
// ----------------------------------------------------------------------------
// sorted_set_neighbor_search
// Ordered set of distinct 31-bit values with insert and neighbor query.
// ----------------------------------------------------------------------------
// One item is handled at a time. Every beat runs a binary search over the
// value memory holding N stored values; each halving reads the middle entry
// and then compares it with the key. A query then reads its lower and upper
// neighbors, each as a read followed by a capture. An insert that lands at
// position p shifts the N-p larger entries up one place, each as a read
// followed by a write, then writes the key. Every beat gives exactly one
// result beat, held until taken. The value store needs no clearing after
// reset: only values from entries below the entry count are ever used.
// ----------------------------------------------------------------------------
module sorted_set_neighbor_search
  import ssns_pkg::*;
#(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic clk_i,
  input  logic rst_ni,
  ssns_in_if.sink    in_i,
  ssns_out_if.source out_o
);

`include "sorted_set_neighbor_search_macros.svh"

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  ctrl_cmd_t     cmd;
  dp_stat_t      stat;
  state_e        state;
  logic [CW-1:0] count;

  // The controller sequences search, shift and read-out phases.
  ssns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .state_o    (state)
  );

  // The datapath owns the memory and all result registers.
  ssns_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_kind_i     (in_i.kind),
    .in_value_i    (in_i.value),
    .out_ready_i   (out_o.ready),
    .status_o      (out_o.status),
    .has_lower_o   (out_o.has_lower),
    .lower_value_o (out_o.lower_value),
    .has_upper_o   (out_o.has_upper),
    .upper_value_o (out_o.upper_value),
    .count_o       (count)
  );

  assign out_o.valid = cmd.out_valid;

  // The entry count never exceeds the capacity.
  `SSNS_ASSERT_IMP(a_cnt_cap, clk_i, rst_ni, 1'b1, count <= CW'(CAPACITY))
  // No new beat is taken while a result is pending.
  `SSNS_ASSERT_IMP(a_no_overlap, clk_i, rst_ni, out_o.valid, !in_i.ready)
  // A completed insert grows the count by exactly one.
  `SSNS_ASSERT_NEXT(a_ins_grow, clk_i, rst_ni, state == S_INS_WR,
                    count == $past(count) + CW'(1))

endmodule
